FILE: rtl/ccrc_pkg.sv
// package with types, register map and crc helper functions of the crc engine
`timescale 1ns / 1ps
`default_nettype none

package ccrc_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned AddrW = 5;

  typedef enum logic [1:0] {
    OP_DATA = 2'd0,
    OP_LAST = 2'd1,
    OP_END  = 2'd2,
    OP_NONE = 2'd3
  } ccrc_op_e;

  typedef enum logic [2:0] {
    REG_WIDTH_MODE  = 3'd0,
    REG_POLYNOMIAL  = 3'd1,
    REG_INIT_VALUE  = 3'd2,
    REG_FINAL_XOR   = 3'd3,
    REG_REFLECT_IN  = 3'd4,
    REG_REFLECT_OUT = 3'd5
  } ccrc_reg_e;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_32 = 2'd2;

  localparam logic [CrcW-1:0] TOP_8  = 32'h0000_0080;
  localparam logic [CrcW-1:0] TOP_16 = 32'h0000_8000;
  localparam logic [CrcW-1:0] TOP_32 = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]      width_mode;
    logic [CrcW-1:0] polynomial;
    logic [CrcW-1:0] init_value;
    logic [CrcW-1:0] final_xor;
    logic            reflect_input;
    logic            reflect_output;
  } ccrc_cfg_t;

  localparam ccrc_cfg_t CFG_RESET = '{
    width_mode:     WIDTH_32,
    polynomial:     32'h04C1_1DB7,
    init_value:     32'hFFFF_FFFF,
    final_xor:      32'hFFFF_FFFF,
    reflect_input:  1'b1,
    reflect_output: 1'b1
  };

  function automatic logic [CrcW-1:0] width_mask(input logic [1:0] mode);
    logic [CrcW-1:0] m;
    case (mode)
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [CrcW-1:0] top_bit(input logic [1:0] mode);
    logic [CrcW-1:0] t;
    case (mode)
      WIDTH_8:  t = TOP_8;
      WIDTH_16: t = TOP_16;
      default:  t = TOP_32;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  // reverse the low width bits, zero above
  function automatic logic [CrcW-1:0] reflect_w(input logic [CrcW-1:0] v,
                                                input logic [1:0]      mode);
    logic [CrcW-1:0] r;
    logic [CrcW-1:0] o;
    for (int i = 0; i < CrcW; i++) begin
      r[i] = v[CrcW-1-i];
    end
    case (mode)
      WIDTH_8:  o = r >> 24;
      WIDTH_16: o = r >> 16;
      default:  o = r;
    endcase
    return o;
  endfunction

  // one byte through eight shift and conditional polynomial steps
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [7:0]      b,
                                               input logic [CrcW-1:0] poly,
                                               input logic [1:0]      mode);
    logic [CrcW-1:0] m;
    logic [CrcW-1:0] p;
    logic [CrcW-1:0] t;
    logic [CrcW-1:0] r;
    m = width_mask(mode);
    t = top_bit(mode);
    p = poly & m;
    case (mode)
      WIDTH_8:  r = crc ^ {24'd0, b};
      WIDTH_16: r = crc ^ {16'd0, b, 8'd0};
      default:  r = crc ^ {b, 24'd0};
    endcase
    r = r & m;
    for (int i = 0; i < 8; i++) begin
      r = ((r << 1) ^ ((|(r & t)) ? p : '0)) & m;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ccrc_if.sv
// valid/ready channel interfaces for crc input bytes and crc results
`timescale 1ns / 1ps
`default_nettype none

interface ccrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface ccrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/ccrc_regs.sv
// apb configuration registers of the crc engine
`timescale 1ns / 1ps
`default_nettype none

module ccrc_regs import ccrc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output ccrc_cfg_t            cfg_o,
  output logic                 reload_o,
  output logic [CrcW-1:0]      reload_value_o
);

  ccrc_cfg_t cfg_q, cfg_d;
  ccrc_reg_e idx;
  logic      wr;

  assign idx   = ccrc_reg_e'(paddr[AddrW-1:2]);
  assign wr    = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_WIDTH_MODE:  cfg_d.width_mode     = pwdata[1:0];
        REG_POLYNOMIAL:  cfg_d.polynomial     = pwdata;
        REG_INIT_VALUE:  cfg_d.init_value     = pwdata;
        REG_FINAL_XOR:   cfg_d.final_xor      = pwdata;
        REG_REFLECT_IN:  cfg_d.reflect_input  = pwdata[0];
        REG_REFLECT_OUT: cfg_d.reflect_output = pwdata[0];
        default: ;
      endcase
    end
  end

  // any write inside the map restarts the message with the new settings
  always_comb begin
    reload_o       = wr && (idx inside {[REG_WIDTH_MODE:REG_REFLECT_OUT]});
    reload_value_o = cfg_d.init_value & width_mask(cfg_d.width_mode);
  end

  always_comb begin
    case (idx)
      REG_WIDTH_MODE:  prdata = {30'd0, cfg_q.width_mode};
      REG_POLYNOMIAL:  prdata = cfg_q.polynomial;
      REG_INIT_VALUE:  prdata = cfg_q.init_value;
      REG_FINAL_XOR:   prdata = cfg_q.final_xor;
      REG_REFLECT_IN:  prdata = {31'd0, cfg_q.reflect_input};
      REG_REFLECT_OUT: prdata = {31'd0, cfg_q.reflect_output};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/configurable_crc_engine.sv
// top level of the configurable crc engine (8, 16 or 32 bit crc, byte per cycle)
//
// in_i carries one byte transfer per cycle: op selects continue, last byte,
// end of message without a byte, or none. out_o carries one crc_value
// transfer for every last-byte or end transfer; other transfers produce nothing.
// an accepted byte lands in an input register; when it advances, the eight
// unrolled shift steps update the running crc and, at a message end, the
// result register is loaded; one byte is taken every cycle while in_i is
// not held.
// the apb port sets width, polynomial, init value, final xor and the two
// reflection flags; every write inside the map reloads the running crc with
// the init value and should only be made while the engine is idle.
// reset loads the default crc-32 settings and clears both channel stages.
// while out_o is stalled with a result waiting, the engine keeps taking
// continue transfers; it holds in_i only when a second result would need
// the occupied output register.
`timescale 1ns / 1ps
`default_nettype none

module configurable_crc_engine import ccrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ccrc_in_if.sink          in_i,
  ccrc_out_if.source       out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ccrc_cfg_t       cfg;
  logic            reload;
  logic [CrcW-1:0] reload_value;

  ccrc_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cfg_o          (cfg),
    .reload_o       (reload),
    .reload_value_o (reload_value)
  );

  logic            s1_valid_q, s1_valid_d;
  ccrc_op_e        s1_op_q;
  logic [7:0]      s1_byte_q;
  logic            out_valid_q, out_valid_d;
  logic [CrcW-1:0] out_crc_q;
  logic [CrcW-1:0] crc_q, crc_d;

  logic            in_xfer;
  logic            needs_out;
  logic            advance;
  logic [7:0]      byte_in;
  logic [CrcW-1:0] crc_upd;
  logic [CrcW-1:0] crc_fin;
  logic [CrcW-1:0] result;
  logic [CrcW-1:0] mask;

  assign mask      = width_mask(cfg.width_mode);
  assign needs_out = (s1_op_q == OP_LAST) || (s1_op_q == OP_END);
  assign advance   = s1_valid_q && (!needs_out || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_xfer   = in_i.valid && in_i.ready;

  always_comb begin
    byte_in = cfg.reflect_input ? rev8(s1_byte_q) : s1_byte_q;
    crc_upd = crc_byte(crc_q, byte_in, cfg.polynomial, cfg.width_mode);
    crc_fin = (s1_op_q == OP_LAST) ? crc_upd : crc_q;
    result  = (cfg.reflect_output ? reflect_w(crc_fin & mask, cfg.width_mode)
                                  : (crc_fin & mask)) ^ (cfg.final_xor & mask);
  end

  always_comb begin
    crc_d = crc_q;
    if (reload) begin
      crc_d = reload_value;
    end else if (advance) begin
      case (s1_op_q)
        OP_DATA:         crc_d = crc_upd;
        OP_LAST, OP_END: crc_d = cfg.init_value & mask;
        default:         crc_d = crc_q;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && needs_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= CFG_RESET.init_value;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      crc_q       <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q   <= ccrc_op_e'(in_i.op);
      s1_byte_q <= in_i.data_byte;
    end
    if (advance && needs_out) begin
      out_crc_q <= result;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = out_crc_q;

endmodule

`default_nettype wire

FILE: rtl/ccrc_checker.sv
// port-level checker of the crc engine and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module ccrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_crc_i,
  input logic        psel_i,
  input logic        pready_i
);

  // a waiting result is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a waiting result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_crc_i))
    else $error("result changed while stalled");

  // input back-pressure only comes from a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input held without a stalled result");

  // input back-pressure is followed by a ready input or a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |=> in_ready_i || out_valid_i)
    else $error("input held with empty output");

  // configuration port never inserts wait states
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i |-> pready_i)
    else $error("apb wait state");

endmodule

bind configurable_crc_engine ccrc_checker u_ccrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_crc_i   (out_o.crc_value),
  .psel_i      (psel),
  .pready_i    (pready)
);

`default_nettype wire

FILE: test/testbench.sv
// self-checking testbench for the configurable crc engine with random traffic and apb setup
`timescale 1ns / 1ps

module testbench;
  import ccrc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 135;
  localparam int unsigned SPARE_REG_LO  = 6;
  localparam int unsigned SPARE_REG_HI  = 7;

  typedef struct packed {
    ccrc_op_e   op;
    logic [7:0] data;
  } crc_item_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  ccrc_in_if  in_ch ();
  ccrc_out_if out_ch ();

  configurable_crc_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // crc shadow state and settings
  logic [1:0]  cfg_mode   = WIDTH_32;
  logic [31:0] cfg_poly   = 32'h04C1_1DB7;
  logic [31:0] cfg_init   = 32'hFFFF_FFFF;
  logic [31:0] cfg_xorout = 32'hFFFF_FFFF;
  logic        cfg_refin  = 1'b1;
  logic        cfg_refout = 1'b1;
  logic [31:0] crc_state  = 32'hFFFF_FFFF;

  crc_item_t   item_queue[$];
  logic [31:0] crc_expected[$];
  int unsigned mismatch_count = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          burst = 1'b0;
  bit          hold_request = 1'b0;
  bit          hold_active = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic int unsigned crc_bits(input logic [1:0] mode);
    case (mode)
      WIDTH_8:  return 8;
      WIDTH_16: return 16;
      default:  return 32;
    endcase
  endfunction

  function automatic logic [31:0] bits_mask(input int unsigned w);
    return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
  endfunction

  function automatic logic [31:0] mirror(input logic [31:0] v, input int unsigned w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < w; i++) begin
      r[w-1-i] = v[i];
    end
    return r;
  endfunction

  // advance the shadow crc by one transfer, returns 1 when a checksum is due
  function automatic bit crc_advance(input ccrc_op_e op, input logic [7:0] data,
                                     output logic [31:0] checksum);
    int unsigned w;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] r;
    logic [31:0] fb;
    logic [7:0]  b;
    bit          msb;
    w = crc_bits(cfg_mode);
    m = bits_mask(w);
    p = cfg_poly & m;
    checksum = '0;
    if (op == OP_NONE) return 1'b0;
    if (op != OP_END) begin
      fb = mirror({24'd0, data}, 8);
      b = cfg_refin ? fb[7:0] : data;
      r = (crc_state ^ ({24'd0, b} << (w - 8))) & m;
      for (int i = 0; i < 8; i++) begin
        msb = r[w-1];
        r = ((r << 1) ^ (msb ? p : 32'd0)) & m;
      end
      crc_state = r;
    end
    if (op == OP_DATA) return 1'b0;
    r = crc_state & m;
    if (cfg_refout) r = mirror(r, w);
    checksum = (r ^ (cfg_xorout & m)) & m;
    crc_state = cfg_init & m;
    return 1'b1;
  endfunction

  function automatic void shadow_write(input int unsigned idx, input logic [31:0] value);
    case (idx)
      REG_WIDTH_MODE:  cfg_mode = value[1:0];
      REG_POLYNOMIAL:  cfg_poly = value;
      REG_INIT_VALUE:  cfg_init = value;
      REG_FINAL_XOR:   cfg_xorout = value;
      REG_REFLECT_IN:  cfg_refin = value[0];
      REG_REFLECT_OUT: cfg_refout = value[0];
      default:         return;
    endcase
    crc_state = cfg_init & bits_mask(crc_bits(cfg_mode));
  endfunction

  function automatic int unsigned draw_gap();
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // input channel driver
  always @(negedge clk_i) begin
    crc_item_t nxt;
    if (!(in_ch.valid && !in_taken)) begin
      if (in_taken) send_gap = draw_gap();
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        nxt = item_queue.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= nxt.op;
        in_ch.data_byte <= nxt.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result channel ready
  always @(negedge clk_i) begin
    if (out_taken) recv_gap = draw_gap();
    if (hold_active) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      if (out_ch.valid) recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // long receiver hold-off
  always begin
    wait (hold_request);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
    hold_request = 1'b0;
  end

  // monitor and checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    logic [31:0] got;
    in_taken  = rst_ni && in_ch.valid && in_ch.ready;
    out_taken = rst_ni && out_ch.valid && out_ch.ready;
    if (out_taken) begin
      if (crc_expected.size() == 0) begin
        $error("crc_value: no result expected, actual %08h", out_ch.crc_value);
        mismatch_count++;
      end else begin
        want = crc_expected.pop_front();
        if (out_ch.crc_value !== want) begin
          $error("crc_value: expected %08h, actual %08h", want, out_ch.crc_value);
          mismatch_count++;
        end
      end
    end
    if (in_taken) begin
      if (crc_advance(ccrc_op_e'(in_ch.op), in_ch.data_byte, got)) crc_expected.push_back(got);
    end
  end

  task automatic reg_write(input int unsigned idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx << 2);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    shadow_write(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_item(input ccrc_op_e op, input logic [7:0] data);
    crc_item_t it;
    it.op = op;
    it.data = data;
    item_queue.push_back(it);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (item_queue.size() != 0 || in_ch.valid || crc_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly complete messages with random content, some noise and open tails
  task automatic queue_traffic(input int unsigned n);
    int unsigned queued;
    int unsigned len;
    bit          use_last;
    queued = 0;
    @(posedge clk_i);
    while (queued < n) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 48) : $urandom_range(0, 8);
      use_last = (len != 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 29) == 0) push_item(OP_NONE, rand_byte());
        if (use_last && i == len - 1) push_item(OP_LAST, rand_byte());
        else push_item(OP_DATA, rand_byte());
      end
      if (!use_last) push_item(OP_END, rand_byte());
      queued += use_last ? len : len + 1;
    end
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(1, 3)) push_item(OP_DATA, rand_byte());
    end
  endtask

  initial begin
    logic [31:0] rnd;
    in_ch.valid     = 1'b0;
    in_ch.op        = OP_DATA;
    in_ch.data_byte = 8'd0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: standard check string, zero-length end, ignored op
    @(posedge clk_i);
    for (int i = 0; i < 9; i++) begin
      if (i == 8) push_item(OP_LAST, 8'h31 + 8'(i));
      else push_item(OP_DATA, 8'h31 + 8'(i));
    end
    push_item(OP_END, 8'h00);
    push_item(OP_DATA, 8'h00);
    push_item(OP_NONE, 8'hA5);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_LAST, 8'h80);
    push_item(OP_DATA, 8'h7F);
    push_item(OP_END, 8'h3C);
    wait_drained();

    // writes past the register list change nothing
    reg_write(SPARE_REG_LO, 32'h0000_0000);
    reg_write(SPARE_REG_HI, 32'h0000_0000);
    @(posedge clk_i);
    push_item(OP_LAST, 8'h01);
    push_item(OP_NONE, 8'hFF);
    push_item(OP_END, 8'h00);
    // message left open across the next settings change
    push_item(OP_DATA, 8'hAA);
    push_item(OP_DATA, 8'h55);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      burst = (ph % 4 == 3);
      rnd = $urandom();
      reg_write(REG_WIDTH_MODE, {rnd[31:2], 2'(ph % 4)});
      reg_write(REG_POLYNOMIAL, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : pick_word());
      reg_write(REG_INIT_VALUE, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : pick_word());
      reg_write(REG_FINAL_XOR, (ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : pick_word());
      rnd = $urandom();
      reg_write(REG_REFLECT_IN, {rnd[31:1], 1'(ph / 4 + ph / 2)});
      rnd = $urandom();
      reg_write(REG_REFLECT_OUT, {rnd[31:1], 1'(ph / 4 + ph)});
      queue_traffic(PHASE_ITEMS);
      if (ph == 2) hold_request = 1'b1;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
